// File: sv/assert_macros.svh
// Assertion macros for the RTL files, used by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define JBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define JBE_ASSERT_NEVER(lbl, cond, msg) `JBE_ASSERT(lbl, !(cond), msg)
`else
`define JBE_ASSERT(lbl, prop, msg)
`define JBE_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: sv/jbe_pkg.sv
// Types, constants and the Huffman code tables of the entropy coder.
`default_nettype none
package jbe_pkg;

  localparam int unsigned CoeffW = 11;
  localparam int unsigned ValW   = 12;
  localparam int unsigned BufW   = 24;
  localparam int unsigned CntW   = 5;
  localparam int unsigned MaxOut = 16;

  localparam logic [1:0] TBL_DC_Y = 2'd0;
  localparam logic [1:0] TBL_AC_Y = 2'd1;
  localparam logic [1:0] TBL_DC_C = 2'd2;
  localparam logic [1:0] TBL_AC_C = 2'd3;

  localparam logic [7:0] SYM_ZRL  = 8'hF0;
  localparam logic [7:0] SYM_EOB  = 8'h00;
  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_00  = 8'h00;

  typedef logic [255:0][20:0] code_tbl_t;
  typedef logic [7:0] cnt_arr_t [16];
  typedef logic [7:0] sym_arr_t [162];

  localparam cnt_arr_t CNT_DC_Y = '{0,1,5,1,1,1,1,1,1,0,0,0,0,0,0,0};
  localparam cnt_arr_t CNT_DC_C = '{0,3,1,1,1,1,1,1,1,1,1,0,0,0,0,0};
  localparam cnt_arr_t CNT_AC_Y = '{0,2,1,3,3,2,4,3,5,5,4,4,0,0,1,8'h7d};
  localparam cnt_arr_t CNT_AC_C = '{0,2,1,2,4,4,3,4,7,5,4,4,0,1,2,8'h77};

  localparam sym_arr_t SYM_AC_Y = '{
    8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,
    8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'hA1,8'h08,8'h23,8'h42,8'hB1,8'hC1,
    8'h15,8'h52,8'hD1,8'hF0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0A,8'h16,8'h17,8'h18,
    8'h19,8'h1A,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2A,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
    8'h3A,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,8'h53,8'h54,8'h55,8'h56,8'h57,
    8'h58,8'h59,8'h5A,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6A,8'h73,8'h74,8'h75,
    8'h76,8'h77,8'h78,8'h79,8'h7A,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8A,8'h92,
    8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9A,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,
    8'hA8,8'hA9,8'hAA,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBA,8'hC2,8'hC3,
    8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hCA,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,8'hD7,8'hD8,
    8'hD9,8'hDA,8'hE1,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hEA,8'hF1,8'hF2,
    8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'hFA};

  localparam sym_arr_t SYM_AC_C = '{
    8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,8'h51,8'h07,
    8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'hA1,8'hB1,8'hC1,8'h09,
    8'h23,8'h33,8'h52,8'hF0,8'h15,8'h62,8'h72,8'hD1,8'h0A,8'h16,8'h24,8'h34,8'hE1,8'h25,
    8'hF1,8'h17,8'h18,8'h19,8'h1A,8'h26,8'h27,8'h28,8'h29,8'h2A,8'h35,8'h36,8'h37,8'h38,
    8'h39,8'h3A,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,8'h53,8'h54,8'h55,8'h56,
    8'h57,8'h58,8'h59,8'h5A,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6A,8'h73,8'h74,
    8'h75,8'h76,8'h77,8'h78,8'h79,8'h7A,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
    8'h8A,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9A,8'hA2,8'hA3,8'hA4,8'hA5,
    8'hA6,8'hA7,8'hA8,8'hA9,8'hAA,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBA,
    8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hCA,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,
    8'hD7,8'hD8,8'hD9,8'hDA,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hEA,8'hF2,
    8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'hFA};

  function automatic sym_arr_t dc_syms();
    sym_arr_t s;
    for (int i = 0; i < 162; i++) s[i] = 8'(i);
    return s;
  endfunction

  // Canonical Huffman build: entry is {length[4:0], code[15:0]}, zero if absent.
  function automatic code_tbl_t build_tbl(cnt_arr_t cnt, sym_arr_t sym, int nsym);
    code_tbl_t   r;
    int unsigned code;
    int k;
    r = '0;
    code = 0;
    k = 0;
    for (int l = 1; l <= 16; l++) begin
      for (int j = 0; j < 256; j++) begin
        if (j < int'(cnt[l-1]) && k < nsym) begin
          r[sym[k]] = {5'(l), code[15:0]};
          code++;
          k++;
        end
      end
      code = code << 1;
    end
    return r;
  endfunction

  // The AC tables take their count lists crosswise.
  localparam code_tbl_t CODE_DC_Y = build_tbl(CNT_DC_Y, dc_syms(), 12);
  localparam code_tbl_t CODE_AC_Y = build_tbl(CNT_AC_C, SYM_AC_Y, 162);
  localparam code_tbl_t CODE_DC_C = build_tbl(CNT_DC_C, dc_syms(), 12);
  localparam code_tbl_t CODE_AC_C = build_tbl(CNT_AC_Y, SYM_AC_C, 162);

  typedef struct packed {
    logic accept;
    logic decide;
    logic zrl_load;
    logic sym_load;
    logic val_load;
    logic pad_load;
    logic drain;
    logic stuff;
    logic finish;
  } jbe_cmd_t;

  typedef struct packed {
    logic func;
    logic pos_zero;
    logic pos_last;
    logic val_zero;
    logic zrun_ge16;
    logic cnt_zero;
    logic cnt_ge8;
    logic byte_ff;
    logic stuff_en;
    logic emit_ok;
    logic finish_ok;
  } jbe_stat_t;

endpackage
`default_nettype wire

// File: sv/jbe_in_if.sv
// Coefficient input channel.
`default_nettype none
interface jbe_in_if;
  logic              valid;
  logic              ready;
  logic              func;
  logic signed [10:0] coeff;
  logic [1:0]        component;
  modport source (output valid, func, coeff, component, input ready);
  modport sink   (input valid, func, coeff, component, output ready);
endinterface
`default_nettype wire

// File: sv/jbe_out_if.sv
// Byte output channel.
`default_nettype none
interface jbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface
`default_nettype wire

// File: sv/jbe_ctrl.sv
// Sequencer for coding one item and draining its bytes.
`default_nettype none
module jbe_ctrl
  import jbe_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  input  jbe_stat_t stat_i,
  output jbe_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_ACRUN  = 4'd2;
  localparam logic [3:0] S_ZRL    = 4'd3;
  localparam logic [3:0] S_SYM    = 4'd4;
  localparam logic [3:0] S_VAL    = 4'd5;
  localparam logic [3:0] S_PAD    = 4'd6;
  localparam logic [3:0] S_DRAIN  = 4'd7;
  localparam logic [3:0] S_STUFF  = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;

  logic [3:0] state_q, state_d;
  logic [3:0] ret_q, ret_d;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept = 1'b1;
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (stat_i.func) state_d = stat_i.cnt_zero ? S_FINISH : S_PAD;
        else if (stat_i.pos_zero) state_d = S_SYM;
        else if (stat_i.val_zero) state_d = stat_i.pos_last ? S_SYM : S_FINISH;
        else state_d = S_ACRUN;
      end
      S_ACRUN: state_d = stat_i.zrun_ge16 ? S_ZRL : S_SYM;
      S_ZRL: begin
        cmd_o.zrl_load = 1'b1;
        ret_d   = S_ACRUN;
        state_d = S_DRAIN;
      end
      S_SYM: begin
        cmd_o.sym_load = 1'b1;
        // end of block symbol carries no magnitude bits
        ret_d   = (!stat_i.pos_zero && stat_i.val_zero) ? S_FINISH : S_VAL;
        state_d = S_DRAIN;
      end
      S_VAL: begin
        cmd_o.val_load = 1'b1;
        ret_d   = S_FINISH;
        state_d = S_DRAIN;
      end
      S_PAD: begin
        cmd_o.pad_load = 1'b1;
        ret_d   = S_FINISH;
        state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat_i.cnt_ge8) state_d = ret_q;
        else if (stat_i.emit_ok) begin
          cmd_o.drain = 1'b1;
          if (stat_i.stuff_en && stat_i.byte_ff) state_d = S_STUFF;
        end
      end
      S_STUFF: begin
        if (stat_i.emit_ok) begin
          cmd_o.stuff = 1'b1;
          state_d     = S_DRAIN;
        end
      end
      S_FINISH: begin
        if (stat_i.finish_ok) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/jbe_dpath.sv
// Predictors, symbol lookup, bit packer and byte output register.
`default_nettype none
module jbe_dpath
  import jbe_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire                     cfg_data_i,
  input  wire                     in_func_i,
  input  wire logic signed [10:0] in_coeff_i,
  input  wire logic [1:0]         in_comp_i,
  input  wire                     in_valid_i,
  input  jbe_cmd_t                cmd_i,
  output jbe_stat_t               stat_o,
  input  wire                     out_ready_i,
  output logic                    out_valid_o,
  output logic [7:0]              out_byte_o,
  output logic                    out_last_o
);

  logic                     func_q;
  logic signed [CoeffW-1:0] coef_q;
  logic [1:0]               comp_q;
  logic signed [ValW-1:0]   val_q, val_d;
  logic signed [CoeffW-1:0] pred_q [3];
  logic [5:0]               pos_q;
  logic [5:0]               zrun_q, zrun_d;
  logic [BufW-1:0]          buf_q, buf_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     stuff_en_q;
  logic [7:0]               held_q;
  logic                     held_v_q;
  logic [CntW-1:0]          emit_n_q;
  logic                     out_v_q, out_last_q;
  logic [7:0]               out_byte_q;

  logic signed [CoeffW-1:0] clamped;
  logic [1:0]               comp_c;
  logic [CoeffW-1:0]        mag;
  logic [3:0]               cat;
  logic [1:0]               tdc, tac;
  logic [7:0]               sym;
  logic [1:0]               tbl;
  logic [20:0]              entry;
  logic [15:0]              ld_code;
  logic [CntW-1:0]          ld_len;
  logic                     load;
  logic [7:0]               drain_byte;
  logic [7:0]               emit_byte;
  logic                     emit;
  logic                     out_free;
  logic                     push;
  logic [7:0]               push_byte;
  logic                     push_last;
  logic [ValW-1:0]          val_bits;

  assign clamped = (in_coeff_i == -11'sd1024) ? -11'sd1023 : in_coeff_i;
  assign comp_c  = (in_comp_i == 2'd3) ? 2'd2 : in_comp_i;
  assign tdc     = (comp_q == 2'd0) ? TBL_DC_Y : TBL_DC_C;
  assign tac     = (comp_q == 2'd0) ? TBL_AC_Y : TBL_AC_C;

  assign mag = val_q[ValW-1] ? CoeffW'(-val_q) : CoeffW'(val_q);
  always_comb begin
    cat = '0;
    for (int i = 0; i < CoeffW; i++) begin
      if (mag[i]) cat = 4'(i + 1);
    end
  end
  assign val_bits = val_q[ValW-1] ? ValW'(val_q - 12'sd1) : ValW'(val_q);

  always_comb begin
    tbl = tac;
    sym = SYM_ZRL;
    if (cmd_i.sym_load) begin
      if (pos_q == 6'd0) begin
        tbl = tdc;
        sym = {4'd0, cat};
      end else if (val_q == '0) begin
        sym = SYM_EOB;
      end else begin
        sym = {zrun_q[3:0], cat};
      end
    end
  end

  always_comb begin
    unique case (tbl)
      TBL_DC_Y: entry = CODE_DC_Y[sym];
      TBL_AC_Y: entry = CODE_AC_Y[sym];
      TBL_DC_C: entry = CODE_DC_C[sym];
      TBL_AC_C: entry = CODE_AC_C[sym];
      default:  entry = '0;
    endcase
  end

  always_comb begin
    ld_code = entry[15:0];
    ld_len  = entry[20:16];
    if (cmd_i.val_load) begin
      ld_code = 16'(val_bits);
      ld_len  = CntW'(cat);
    end else if (cmd_i.pad_load) begin
      ld_code = 16'hFFFF;
      ld_len  = CntW'(5'd8 - cnt_q);
    end
  end
  assign load = cmd_i.zrl_load | cmd_i.sym_load | cmd_i.val_load | cmd_i.pad_load;

  assign drain_byte = 8'(buf_q >> (cnt_q - CntW'(8)));
  assign emit_byte  = cmd_i.stuff ? BYTE_00 : drain_byte;
  assign emit       = cmd_i.drain | cmd_i.stuff;
  assign out_free   = !out_v_q || out_ready_i;

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (load) begin
      buf_d = (buf_q << ld_len) | (BufW'(ld_code) & ((BufW'(1) << ld_len) - BufW'(1)));
      cnt_d = cnt_q + ld_len;
    end else if (cmd_i.drain) begin
      cnt_d = cnt_q - CntW'(8);
    end
  end

  // A flush leaves the run and the coding value alone.
  always_comb begin
    val_d  = val_q;
    zrun_d = zrun_q;
    if (cmd_i.decide && !func_q) begin
      if (pos_q == 6'd0) begin
        val_d  = ValW'(coef_q) - ValW'(pred_q[comp_q]);
        zrun_d = '0;
      end else begin
        val_d = ValW'(coef_q);
        if (coef_q == '0) zrun_d = zrun_q + 6'd1;
      end
    end else if (cmd_i.zrl_load) begin
      zrun_d = zrun_q - 6'd16;
    end else if (cmd_i.sym_load && pos_q != 6'd0 && val_q != '0) begin
      zrun_d = '0;
    end else if (cmd_i.finish && !func_q && pos_q == 6'd63) begin
      zrun_d = '0;
    end
  end

  // Hold one byte back so the final byte of an item can carry last.
  always_comb begin
    push      = 1'b0;
    push_byte = held_q;
    push_last = 1'b0;
    if (emit && emit_n_q < CntW'(MaxOut) && held_v_q) push = 1'b1;
    if (cmd_i.finish && held_v_q) begin
      push      = 1'b1;
      push_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q     <= '{default: '0};
      pos_q      <= '0;
      zrun_q     <= '0;
      cnt_q      <= '0;
      stuff_en_q <= 1'b1;
      held_v_q   <= 1'b0;
      emit_n_q   <= '0;
      out_v_q    <= 1'b0;
    end else begin
      zrun_q <= zrun_d;
      cnt_q  <= cnt_d;
      if (cfg_we_i) stuff_en_q <= cfg_data_i;
      if (cmd_i.accept && in_valid_i) emit_n_q <= '0;
      if (cmd_i.decide && !func_q && pos_q == 6'd0) pred_q[comp_q] <= coef_q;
      if (emit && emit_n_q < CntW'(MaxOut)) begin
        held_v_q <= 1'b1;
        emit_n_q <= emit_n_q + CntW'(1);
      end
      if (cmd_i.finish) begin
        held_v_q <= 1'b0;
        if (!func_q) pos_q <= pos_q + 6'd1;
      end
      if (push) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    val_q <= val_d;
    if (cmd_i.accept && in_valid_i) begin
      func_q <= in_func_i;
      coef_q <= clamped;
      comp_q <= comp_c;
    end
    if (emit && emit_n_q < CntW'(MaxOut)) held_q <= emit_byte;
    if (push) begin
      out_byte_q <= push_byte;
      out_last_q <= push_last;
    end
  end

  assign stat_o.func      = func_q;
  assign stat_o.pos_zero  = (pos_q == 6'd0);
  assign stat_o.pos_last  = (pos_q == 6'd63);
  assign stat_o.val_zero  = (coef_q == '0);
  assign stat_o.zrun_ge16 = (zrun_q >= 6'd16);
  assign stat_o.cnt_zero  = (cnt_q == '0);
  assign stat_o.cnt_ge8   = (cnt_q >= CntW'(8));
  assign stat_o.byte_ff   = (drain_byte == BYTE_FF);
  assign stat_o.stuff_en  = stuff_en_q;
  assign stat_o.emit_ok   = (emit_n_q >= CntW'(MaxOut)) || !held_v_q || out_free;
  assign stat_o.finish_ok = !held_v_q || out_free;

  assign out_valid_o = out_v_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

// File: sv/jpeg_block_entropy_coder.sv
// Top level of the baseline Huffman entropy coder for 8x8 coefficient blocks.
//
// Input channel in_ch_i: one transfer per item. func 0 codes one quantized
// coefficient (zigzag order, 64 per block, first is DC) of the given component;
// func 1 pads the pending bits with ones to a byte boundary and drains them.
// Output channel out_ch_o: one transfer per byte of the coded stream, MSB first,
// with last set on the final byte caused by an item. An item that completes no
// byte produces no transfer.
// Timing: one item at a time, from one accept to the next; the sequencer runs
// lookup, load and drain in turn, with each ZRL symbol, the code symbol and the
// magnitude bits loaded and drained in turn, and each output byte or stuffed
// zero sent out as its own drain or stuff step.
// Stuffing: with stuffing_enable_i set (reset value 1) a zero byte follows
// every 0xFF. Write the register through stuffing_enable_we_i only while idle.
// Reset: clears the bit packer, the DC predictors and the block position.
// The code tables are constant and need no load time.
// Stall: when the receiver holds ready low the byte sits in the output register
// and the coder stops in its drain, stuff or finish step until the transfer.
`default_nettype none
`include "assert_macros.svh"
module jpeg_block_entropy_coder
  import jbe_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        stuffing_enable_we_i,
  input  wire        stuffing_enable_i,
  jbe_in_if.sink     in_ch_i,
  jbe_out_if.source  out_ch_o
);

  jbe_cmd_t  cmd;
  jbe_stat_t stat;

  // command stream from the sequencer
  jbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // coding state, bit packer and output register
  jbe_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (stuffing_enable_we_i),
    .cfg_data_i  (stuffing_enable_i),
    .in_func_i   (in_ch_i.func),
    .in_coeff_i  (in_ch_i.coeff),
    .in_comp_i   (in_ch_i.component),
    .in_valid_i  (in_ch_i.valid),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ch_o.ready),
    .out_valid_o (out_ch_o.valid),
    .out_byte_o  (out_ch_o.out_byte),
    .out_last_o  (out_ch_o.last)
  );

  assign in_ch_i.ready = cmd.accept;

  // a new item only starts once the held byte of the last one has gone out
  `JBE_ASSERT(a_accept_no_held, cmd.accept |-> stat.finish_ok, "held byte at accept")
  // drain leaves fewer than eight bits before an item is taken
  `JBE_ASSERT_NEVER(a_idle_cnt, cmd.accept && stat.cnt_ge8, "undrained byte at accept")
  // a stuffed zero only goes out while stuffing is on
  `JBE_ASSERT(a_stuff_en, cmd.stuff |-> stat.stuff_en, "stuffed zero with stuffing off")

endmodule
`default_nettype wire

// File: tb/sv/jpeg_block_entropy_coder_tb.sv
// Self-checking testbench of the block entropy coder: directed table, then randomised blocks.
`timescale 1ns / 100ps
module jpeg_block_entropy_coder_tb
  import jbe_pkg::*;
();

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned HoldOffCycles = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_d = 1'b0;

  jbe_in_if  coef_ch ();
  jbe_out_if byte_ch ();

  jpeg_block_entropy_coder u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .stuffing_enable_we_i (cfg_we),
    .stuffing_enable_i    (cfg_d),
    .in_ch_i              (coef_ch),
    .out_ch_o             (byte_ch)
  );

  always #5 clk_i = ~clk_i;

  // Shadow state of the coder, updated on every accepted item transfer.
  logic [20:0] huff_code [1024];
  logic [63:0] bit_acc;
  int          bit_cnt;
  int          dc_pred [3];
  int          blk_pos;
  int          zero_run;
  logic        stuff_en;
  logic [7:0]  item_bytes [$];
  logic [7:0]  exp_bytes [$];
  logic        exp_last [$];

  int unsigned snd_idle;
  int unsigned rcv_idle;
  logic        hold_off = 1'b0;
  int          n_err = 0;
  int          n_row_err;
  int          n_bytes = 0;
  int          n_items;
  int          n_flush;

  // Canonical Huffman build from a count list and a symbol list.
  function automatic void build_huff(int base, cnt_arr_t cnt, sym_arr_t sym, int nsym);
    int unsigned code;
    int k;
    code = 0;
    k = 0;
    for (int j = 0; j < 256; j++) huff_code[base + j] = '0;
    for (int l = 1; l <= 16; l++) begin
      for (int j = 0; j < int'(cnt[l-1]) && k < nsym; j++) begin
        huff_code[base + int'(sym[k])] = {5'(l), code[15:0]};
        code++;
        k++;
      end
      code = code << 1;
    end
  endfunction

  function automatic void push_byte(logic [7:0] b);
    if (item_bytes.size() < MaxOut) item_bytes.push_back(b);
  endfunction

  function automatic void pack_bits(logic [31:0] code, int len);
    logic [7:0] b;
    if (len == 0 || len > 16) return;
    bit_acc = (bit_acc << len) | 64'(code & ((32'd1 << len) - 1));
    bit_cnt += len;
    while (bit_cnt >= 8) begin
      b = 8'(bit_acc >> (bit_cnt - 8));
      bit_cnt -= 8;
      push_byte(b);
      if (stuff_en && b == BYTE_FF) push_byte(BYTE_00);
    end
    bit_acc &= (64'd1 << bit_cnt) - 1;
  endfunction

  function automatic void pack_symbol(logic [1:0] tbl, logic [7:0] sym);
    logic [20:0] e;
    e = huff_code[{tbl, sym}];
    pack_bits(32'(e[15:0]), int'(e[20:16]));
  endfunction

  function automatic int size_class(int mag);
    int s;
    s = 0;
    while (mag != 0 && s < 16) begin
      mag >>= 1;
      s++;
    end
    return s;
  endfunction

  // One's-complement tail bits: negative values go out as v - 1 truncated.
  function automatic void pack_amplitude(int v, int s);
    pack_bits(32'(v < 0 ? v - 1 : v), s);
  endfunction

  // Work out the bytes one accepted item causes and queue them as expected.
  function automatic void encode_item(logic f, logic signed [10:0] c, logic [1:0] k);
    int comp, v, d, s;
    logic [1:0] tdc, tac;
    item_bytes.delete();
    comp = (k > 2) ? 2 : int'(k);
    tdc = (comp == 0) ? TBL_DC_Y : TBL_DC_C;
    tac = (comp == 0) ? TBL_AC_Y : TBL_AC_C;
    if (f) begin
      if (bit_cnt > 0) pack_bits((32'd1 << (8 - bit_cnt)) - 1, 8 - bit_cnt);
    end else begin
      v = int'(c);
      if (v < -1023) v = -1023;
      if (blk_pos == 0) begin
        d = v - dc_pred[comp];
        s = size_class(d < 0 ? -d : d);
        dc_pred[comp] = v;
        pack_symbol(tdc, 8'(s));
        pack_amplitude(d, s);
        zero_run = 0;
      end else if (v == 0) begin
        zero_run++;
        if (blk_pos == 63) pack_symbol(tac, SYM_EOB);
      end else begin
        s = size_class(v < 0 ? -v : v);
        while (zero_run >= 16) begin
          pack_symbol(tac, SYM_ZRL);
          zero_run -= 16;
        end
        pack_symbol(tac, {4'(zero_run), 4'(s)});
        pack_amplitude(v, s);
        zero_run = 0;
      end
      blk_pos = (blk_pos + 1) % 64;
      if (blk_pos == 0) zero_run = 0;
    end
    foreach (item_bytes[i]) begin
      exp_bytes.push_back(item_bytes[i]);
      exp_last.push_back(i == item_bytes.size() - 1);
    end
  endfunction

  // Offer one item at the falling edge, hold it until the transfer, then predict.
  task automatic send_item(logic f, logic signed [10:0] c, logic [1:0] k);
    while ($urandom_range(99) < snd_idle) begin
      coef_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    coef_ch.valid = 1'b1;
    coef_ch.func = f;
    coef_ch.coeff = c;
    coef_ch.component = k;
    do @(posedge clk_i); while (!coef_ch.ready);
    encode_item(f, c, k);
    n_items++;
    if (f) n_flush++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    coef_ch.valid = 1'b0;
    while (exp_bytes.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_stuffing(logic val);
    wait_idle();
    cfg_we = 1'b1;
    cfg_d = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    stuff_en = val;
  endtask

  // Mostly well-formed blocks: one component per block, sparse AC, some noise.
  task automatic send_random(int count);
    logic [1:0] blk_comp;
    logic signed [10:0] c;
    int r;
    blk_comp = 2'($urandom_range(0, 3));
    repeat (count) begin
      if (blk_pos == 0) blk_comp = 2'($urandom_range(0, 3));
      r = $urandom_range(99);
      if (r < 3) begin
        send_item(1'b1, 11'($urandom_range(0, 2047)), 2'($urandom_range(0, 3)));
        continue;
      end
      r = $urandom_range(99);
      if (blk_pos != 0 && r < 55) c = '0;
      else if (r < 85) c = ($urandom_range(1) ? 11'sd1 : -11'sd1) * 11'($urandom_range(1, 15));
      else if (r < 95) c = 11'($urandom_range(0, 2047));
      else c = $urandom_range(1) ? 11'sd1023 : -11'sd1024;
      send_item(1'b0, c, ($urandom_range(99) < 5) ? 2'($urandom_range(0, 3)) : blk_comp);
    end
  endtask

  // Receiver: drop ready at random, or for a long stretch while held off.
  always @(negedge clk_i) begin
    byte_ch.ready <= !hold_off && ($urandom_range(99) >= rcv_idle);
  end

  // Compare every byte transfer with the oldest expected byte.
  always @(posedge clk_i) begin
    if (rst_ni && byte_ch.valid && byte_ch.ready) begin
      n_bytes++;
      if (exp_bytes.size() == 0) begin
        $display("%0t: unexpected byte 0x%02h last %0b", $time, byte_ch.out_byte, byte_ch.last);
        n_err++;
      end else begin
        if (byte_ch.out_byte !== exp_bytes[0] || byte_ch.last !== exp_last[0]) begin
          $display("%0t: byte mismatch, expected 0x%02h last %0b, got 0x%02h last %0b",
                   $time, exp_bytes[0], exp_last[0], byte_ch.out_byte, byte_ch.last);
          n_err++;
        end
        void'(exp_bytes.pop_front());
        void'(exp_last.pop_front());
      end
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((coef_ch.valid && coef_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired, %0d bytes outstanding", $time, exp_bytes.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  typedef struct {
    logic               f;
    logic signed [10:0] c;
    logic [1:0]         k;
    int                 reps;
    logic               typed;
    int                 n_typed;
    logic [7:0]         b_typed;
  } stim_row_t;

  // Directed rows; typed rows carry the bytes that can be read off at once.
  stim_row_t dir_rows [18] = '{
    '{1'b1, 11'sd0,     2'd0, 1,  1'b1, 0, 8'h00},  // flush straight after reset: nothing
    '{1'b0, 11'sd0,     2'd0, 1,  1'b0, 0, 8'h00},  // DC zero, category 0 code 00
    '{1'b1, 11'sd0,     2'd0, 1,  1'b1, 1, 8'h3F},  // pad six ones
    '{1'b1, 11'sd0,     2'd1, 1,  1'b1, 0, 8'h00},  // flush with nothing pending
    '{1'b0, -11'sd1024, 2'd0, 1,  1'b0, 0, 8'h00},  // clamped to -1023
    '{1'b0, 11'sd1023,  2'd0, 1,  1'b0, 0, 8'h00},
    '{1'b0, -11'sd1,    2'd0, 1,  1'b0, 0, 8'h00},
    '{1'b0, 11'sd1,     2'd0, 1,  1'b0, 0, 8'h00},
    '{1'b0, 11'sd0,     2'd0, 20, 1'b0, 0, 8'h00},  // run of 20: one ZRL then run 4
    '{1'b0, 11'sd5,     2'd0, 1,  1'b0, 0, 8'h00},
    '{1'b0, 11'sd7,     2'd1, 1,  1'b0, 0, 8'h00},  // component change inside the block
    '{1'b0, 11'sd0,     2'd3, 37, 1'b0, 0, 8'h00},  // trailing zeros end in EOB
    '{1'b0, -11'sd1023, 2'd2, 1,  1'b0, 0, 8'h00},  // Cr DC
    '{1'b0, 11'sd0,     2'd2, 62, 1'b0, 0, 8'h00},  // long run, three ZRLs
    '{1'b0, -11'sd3,    2'd2, 1,  1'b0, 0, 8'h00},  // last position nonzero: no EOB
    '{1'b0, 11'sd1023,  2'd3, 1,  1'b0, 0, 8'h00},  // component 3 as Cr, DC diff 2046
    '{1'b0, 11'sd0,     2'd3, 63, 1'b0, 0, 8'h00},
    '{1'b1, 11'sd0,     2'd0, 1,  1'b0, 0, 8'h00}
  };

  initial begin
    sym_arr_t dc_sym;
    coef_ch.valid = 1'b0;
    coef_ch.func = 1'b0;
    coef_ch.coeff = '0;
    coef_ch.component = '0;
    n_row_err = 0;
    n_items = 0;
    n_flush = 0;
    for (int i = 0; i < 162; i++) dc_sym[i] = 8'(i);
    // Same pairing of count and symbol lists as the coder uses.
    build_huff(0,   CNT_DC_Y, dc_sym,   12);
    build_huff(256, CNT_AC_C, SYM_AC_Y, 162);
    build_huff(512, CNT_DC_C, dc_sym,   12);
    build_huff(768, CNT_AC_Y, SYM_AC_C, 162);
    bit_acc = '0;
    bit_cnt = 0;
    dc_pred = '{0, 0, 0};
    blk_pos = 0;
    zero_run = 0;
    stuff_en = 1'b1;
    snd_idle = 9;
    rcv_idle = 71;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps) begin
        send_item(dir_rows[r].f, dir_rows[r].c, dir_rows[r].k);
        if (dir_rows[r].typed && (item_bytes.size() != dir_rows[r].n_typed ||
            (dir_rows[r].n_typed > 0 && item_bytes[0] != dir_rows[r].b_typed))) begin
          $display("%0t: row %0d predicted %0d bytes, expected %0d (0x%02h)", $time, r,
                   item_bytes.size(), dir_rows[r].n_typed, dir_rows[r].b_typed);
          n_row_err++;
        end
      end
    end

    write_stuffing(1'b0);
    send_random(35);
    write_stuffing(1'b1);
    snd_idle = 71;
    rcv_idle = 9;
    send_random(35);
    write_stuffing(1'b0);
    write_stuffing(1'b1);
    snd_idle = 0;
    rcv_idle = 0;
    // Hold the receiver off while the sender keeps offering, so the coder backs up.
    fork
      begin
        hold_off = 1'b1;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    send_random(35);
    send_item(1'b1, 11'sd0, 2'd0);
    wait_idle();

    $display("Covered %0d items (%0d flushes) and %0d output bytes,", n_items, n_flush, n_bytes);
    $display("with stuffing on and off, three idle mixes and one long receiver stall.");
    if (n_err + n_row_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_err + n_row_err);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
